FILE: sv/aasp_pkg.sv
// ----------------------------------------------------------------------------
// aasp_pkg: shared types and constants of the ADC averager
// Payload structs, serial arithmetic request and response, sequencer codes.
// ----------------------------------------------------------------------------
package aasp_pkg;

  // Field widths of the transactions.
  localparam int unsigned SAMPLE_W   = 10;
  localparam int unsigned CFG_W      = 13;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned BAT_MV_W   = 13;
  localparam int unsigned IN_MV_W    = 15;
  localparam int unsigned IN_MA_W    = 11;
  localparam int unsigned PWR_W      = 25;
  localparam int unsigned BAT_MA_W   = 16;

  // Serial arithmetic unit: working register, operand and step counter widths.
  localparam int unsigned XW   = 28;
  localparam int unsigned YW   = 13;
  localparam int unsigned LW   = $clog2(XW + 1);
  // Average times reference voltage.
  localparam int unsigned PROD_W = SAMPLE_W + CFG_W;

  // Defaults.
  localparam int unsigned SCANS_PER_AVERAGE_DEF = 8;
  localparam logic [CFG_W-1:0] REF_VOLTAGE_RESET = 13'd4860;
  localparam logic [CFG_W-1:0] MIN_BATTERY_RESET = 13'd500;

  // Fixed scaling divisors.
  localparam logic [YW-1:0] DIV_BATTERY = 13'd1023;
  localparam logic [YW-1:0] DIV_VOLTAGE = 13'd208;
  localparam logic [YW-1:0] DIV_CURRENT = 13'd5115;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_REF_VOLTAGE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_BATTERY = 2'd1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] battery_sample;
    logic [SAMPLE_W-1:0] voltage_sample;
    logic [SAMPLE_W-1:0] current_sample;
  } aasp_in_t;

  typedef struct packed {
    logic [BAT_MV_W-1:0] battery_mv;
    logic [IN_MV_W-1:0]  input_mv;
    logic [IN_MA_W-1:0]  input_ma;
    logic [PWR_W-1:0]    power_uw;
    logic [BAT_MA_W-1:0] battery_ma;
  } aasp_out_t;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } aasp_op_e;

  // Request to the serial unit; a divide expects its dividend left aligned.
  typedef struct packed {
    logic          start;
    aasp_op_e      op;
    logic [XW-1:0] a;
    logic [YW-1:0] b;
    logic [LW-1:0] len;
  } aasp_alu_req_t;

  typedef struct packed {
    logic          busy;
    logic          done;
    logic [XW-1:0] result;
  } aasp_alu_rsp_t;

  typedef enum logic [3:0] {
    ST_ACC,
    ST_AVG_B,
    ST_MUL_B,
    ST_DIV_B,
    ST_AVG_V,
    ST_MUL_V,
    ST_DIV_V,
    ST_AVG_C,
    ST_MUL_C,
    ST_DIV_C,
    ST_PWR,
    ST_BAT,
    ST_OUT
  } aasp_state_e;

endpackage

FILE: sv/aasp_serial_alu.sv
// ----------------------------------------------------------------------------
// aasp_serial_alu: bit-serial multiply and divide
// Shift-and-add multiply and restoring divide, one bit per cycle.
// ----------------------------------------------------------------------------
module aasp_serial_alu (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  aasp_pkg::aasp_alu_req_t req_i,
  output aasp_pkg::aasp_alu_rsp_t rsp_o
);
  import aasp_pkg::*;

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  aasp_op_e      op_q, op_d;
  logic [LW-1:0] cnt_q, cnt_d;
  logic [XW-1:0] x_q, x_d;
  logic [YW-1:0] y_q, y_d;
  logic [XW-1:0] acc_q, acc_d;

  logic [YW:0]   rem_ext;
  logic          rem_ge;
  logic [YW:0]   rem_new;

  // One restoring division step: bring down the next dividend bit.
  always_comb begin
    rem_ext = {acc_q[YW-1:0], x_q[XW-1]};
    rem_ge  = (rem_ext >= {1'b0, y_q});
    rem_new = rem_ge ? (rem_ext - {1'b0, y_q}) : rem_ext;
  end

  // Load on start, then step until the counter runs out.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    x_d    = x_q;
    y_d    = y_q;
    acc_d  = acc_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      cnt_d  = req_i.len;
      x_d    = req_i.a;
      y_d    = req_i.b;
      acc_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q - LW'(1);
      if (cnt_q == LW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
      unique case (op_q)
        OP_MUL: begin
          if (y_q[0]) begin
            acc_d = acc_q + x_q;
          end
          x_d = {x_q[XW-2:0], 1'b0};
          y_d = {1'b0, y_q[YW-1:1]};
        end
        OP_DIV: begin
          acc_d = XW'(rem_new[YW-1:0]);
          x_d   = {x_q[XW-2:0], rem_ge};
        end
        default: begin
          acc_d = acc_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_MUL;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    acc_q <= acc_d;
  end

  // Product sits in the accumulator, quotient in the shift register.
  assign rsp_o.busy   = busy_q;
  assign rsp_o.done   = done_q;
  assign rsp_o.result = (op_q == OP_MUL) ? acc_q : x_q;

endmodule

FILE: sv/adc_average_scale_power_core.sv
// ----------------------------------------------------------------------------
// adc_average_scale_power_core: boxcar ADC averager with power calculation
// Averages blocks of scans, scales to mV and mA, computes power and current.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+----------------------------
//  in      | input     | in_valid_i / in_ready_o | in_data_i (three samples)
//  out     | output    | out_valid_o/out_ready_i | out_data_o (five results)
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// A scan that does not close a block is only added to the sums. The last scan of a
// block starts up to eleven multiply and divide steps on one bit-serial unit, during
// which no input is taken; the last division is skipped when the battery is at or
// below the threshold. A result waits in the output register while scans resume;
// the next block stalls until it is taken. Reset loads the register defaults and
// clears the sums.
// ----------------------------------------------------------------------------
module adc_average_scale_power_core #(
  parameter int unsigned SCANS_PER_AVERAGE = aasp_pkg::SCANS_PER_AVERAGE_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  aasp_pkg::aasp_in_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output aasp_pkg::aasp_out_t                 out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [aasp_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [aasp_pkg::CFG_W-1:0]          cfg_data_i
);
  import aasp_pkg::*;

  localparam int unsigned SUM_W = $clog2(1023 * SCANS_PER_AVERAGE + 1);
  localparam int unsigned CNT_W = $clog2(SCANS_PER_AVERAGE);

  aasp_state_e         state_q, state_d;
  logic [CNT_W-1:0]    scan_cnt_q, scan_cnt_d;
  logic [SUM_W-1:0]    sum_b_q, sum_b_d;
  logic [SUM_W-1:0]    sum_v_q, sum_v_d;
  logic [SUM_W-1:0]    sum_c_q, sum_c_d;
  logic [CFG_W-1:0]    ref_q;
  logic [CFG_W-1:0]    min_q;
  logic [BAT_MV_W-1:0] bm_q, bm_d;
  logic [IN_MV_W-1:0]  mv_q, mv_d;
  logic [IN_MA_W-1:0]  ma_q, ma_d;
  logic [PWR_W-1:0]    pwr_q, pwr_d;
  logic [BAT_MA_W-1:0] bma_q, bma_d;
  logic                out_valid_q, out_valid_d;
  aasp_out_t           out_q, out_d;

  aasp_alu_req_t       alu_req;
  aasp_alu_rsp_t       alu_rsp;
  logic                alu_idle;
  logic [XW-1:0]       prod_aligned;
  logic [XW-1:0]       avg_ext;

  aasp_serial_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  // Operands taken from the previous step's result.
  assign alu_idle     = !alu_rsp.busy && !alu_rsp.done;
  assign avg_ext      = XW'(alu_rsp.result[SAMPLE_W-1:0]);
  assign prod_aligned = XW'(alu_rsp.result[PROD_W-1:0]) << (XW - PROD_W);

  // Sequencer: accumulate scans, then walk the arithmetic steps.
  always_comb begin
    state_d     = state_q;
    scan_cnt_d  = scan_cnt_q;
    sum_b_d     = sum_b_q;
    sum_v_d     = sum_v_q;
    sum_c_d     = sum_c_q;
    bm_d        = bm_q;
    mv_d        = mv_q;
    ma_d        = ma_q;
    pwr_d       = pwr_q;
    bma_d       = bma_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    alu_req.start = 1'b0;
    alu_req.op    = OP_DIV;
    alu_req.a     = '0;
    alu_req.b     = '0;
    alu_req.len   = '0;

    unique case (state_q)
      ST_ACC: begin
        if (in_valid_i) begin
          sum_b_d = sum_b_q + SUM_W'(in_data_i.battery_sample);
          sum_v_d = sum_v_q + SUM_W'(in_data_i.voltage_sample);
          sum_c_d = sum_c_q + SUM_W'(in_data_i.current_sample);
          if (scan_cnt_q == CNT_W'(SCANS_PER_AVERAGE - 1)) begin
            scan_cnt_d = '0;
            state_d    = ST_AVG_B;
          end else begin
            scan_cnt_d = scan_cnt_q + CNT_W'(1);
          end
        end
      end
      ST_AVG_B, ST_AVG_V, ST_AVG_C: begin
        alu_req.start = alu_idle;
        alu_req.op    = OP_DIV;
        alu_req.b     = YW'(SCANS_PER_AVERAGE);
        alu_req.len   = LW'(SUM_W);
        priority if (state_q == ST_AVG_B) begin
          alu_req.a = XW'(sum_b_q) << (XW - SUM_W);
        end else if (state_q == ST_AVG_V) begin
          alu_req.a = XW'(sum_v_q) << (XW - SUM_W);
        end else begin
          alu_req.a = XW'(sum_c_q) << (XW - SUM_W);
        end
        if (alu_rsp.done) begin
          priority if (state_q == ST_AVG_B) begin
            state_d = ST_MUL_B;
          end else if (state_q == ST_AVG_V) begin
            state_d = ST_MUL_V;
          end else begin
            state_d = ST_MUL_C;
          end
        end
      end
      ST_MUL_B, ST_MUL_V, ST_MUL_C: begin
        alu_req.start = alu_idle;
        alu_req.op    = OP_MUL;
        alu_req.a     = avg_ext;
        alu_req.b     = ref_q;
        alu_req.len   = LW'(CFG_W);
        if (alu_rsp.done) begin
          priority if (state_q == ST_MUL_B) begin
            state_d = ST_DIV_B;
          end else if (state_q == ST_MUL_V) begin
            state_d = ST_DIV_V;
          end else begin
            state_d = ST_DIV_C;
          end
        end
      end
      ST_DIV_B: begin
        alu_req.start = alu_idle;
        alu_req.a     = prod_aligned;
        alu_req.b     = DIV_BATTERY;
        alu_req.len   = LW'(PROD_W);
        if (alu_rsp.done) begin
          bm_d    = (alu_rsp.result > XW'({BAT_MV_W{1'b1}})) ? '1
                                                             : alu_rsp.result[BAT_MV_W-1:0];
          state_d = ST_AVG_V;
        end
      end
      ST_DIV_V: begin
        alu_req.start = alu_idle;
        alu_req.a     = prod_aligned;
        alu_req.b     = DIV_VOLTAGE;
        alu_req.len   = LW'(PROD_W);
        if (alu_rsp.done) begin
          mv_d    = (alu_rsp.result > XW'({IN_MV_W{1'b1}})) ? '1
                                                            : alu_rsp.result[IN_MV_W-1:0];
          state_d = ST_AVG_C;
        end
      end
      ST_DIV_C: begin
        alu_req.start = alu_idle;
        alu_req.a     = prod_aligned;
        alu_req.b     = DIV_CURRENT;
        alu_req.len   = LW'(PROD_W);
        if (alu_rsp.done) begin
          ma_d    = (alu_rsp.result > XW'({IN_MA_W{1'b1}})) ? '1
                                                            : alu_rsp.result[IN_MA_W-1:0];
          state_d = ST_PWR;
        end
      end
      ST_PWR: begin
        alu_req.start = alu_idle;
        alu_req.op    = OP_MUL;
        alu_req.a     = XW'(mv_q);
        alu_req.b     = YW'(ma_q);
        alu_req.len   = LW'(IN_MA_W);
        if (alu_rsp.done) begin
          pwr_d   = (alu_rsp.result > XW'({PWR_W{1'b1}})) ? '1
                                                          : alu_rsp.result[PWR_W-1:0];
          state_d = ST_BAT;
        end
      end
      ST_BAT: begin
        // Battery current only above the threshold; this also keeps the
        // divisor nonzero.
        if (bm_q > min_q) begin
          alu_req.start = alu_idle;
          alu_req.a     = XW'(pwr_q) << (XW - PWR_W);
          alu_req.b     = YW'(bm_q);
          alu_req.len   = LW'(PWR_W);
          if (alu_rsp.done) begin
            bma_d   = (alu_rsp.result > XW'({BAT_MA_W{1'b1}})) ? '1
                                                               : alu_rsp.result[BAT_MA_W-1:0];
            state_d = ST_OUT;
          end
        end else begin
          bma_d   = '0;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d      = 1'b1;
          out_d.battery_mv = bm_q;
          out_d.input_mv   = mv_q;
          out_d.input_ma   = ma_q;
          out_d.power_uw   = pwr_q;
          out_d.battery_ma = bma_q;
          sum_b_d          = '0;
          sum_v_d          = '0;
          sum_c_d          = '0;
          state_d          = ST_ACC;
        end
      end
      default: begin
        state_d = ST_ACC;
      end
    endcase
  end

  // Control state and running sums.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACC;
      scan_cnt_q  <= '0;
      sum_b_q     <= '0;
      sum_v_q     <= '0;
      sum_c_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_cnt_q  <= scan_cnt_d;
      sum_b_q     <= sum_b_d;
      sum_v_q     <= sum_v_d;
      sum_c_q     <= sum_c_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q <= REF_VOLTAGE_RESET;
      min_q <= MIN_BATTERY_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_REF_VOLTAGE) begin
        ref_q <= cfg_data_i;
      end
      if (cfg_index_i == CFG_MIN_BATTERY) begin
        min_q <= cfg_data_i;
      end
    end
  end

  // Intermediate results and the output register.
  always_ff @(posedge clk_i) begin
    bm_q  <= bm_d;
    mv_q  <= mv_d;
    ma_q  <= ma_d;
    pwr_q <= pwr_d;
    bma_q <= bma_d;
    out_q <= out_d;
  end

  assign in_ready_o  = (state_q == ST_ACC);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Scans are only taken while the serial unit is quiet.
  a_ready_alu_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !alu_rsp.busy)
    else $error("scan accepted while the serial unit is busy");

  // The serial unit reports completion for a single cycle.
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_rsp.done |=> !alu_rsp.done)
    else $error("serial unit done held longer than one cycle");

  // The scan counter is back at zero for the whole calculation.
  a_cnt_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_ACC) |-> (scan_cnt_q == '0))
    else $error("scan counter not cleared during calculation");

  // Battery current implies a nonzero battery voltage.
  a_bat_ma_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.battery_ma != '0)) |-> (out_data_o.battery_mv != '0))
    else $error("battery current reported with zero battery voltage");

endmodule
